[rtl/bps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// Shared widths, register codes and stage types of the bit pattern search.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int WORD_BITS     = 64;
    localparam int WIN_WORDS     = 4;
    localparam int WIN_BITS      = WIN_WORDS * WORD_BITS;
    localparam int SPAN_BITS     = WIN_BITS + WORD_BITS;
    localparam int PATTERN_BITS  = 200;
    localparam int TOP_BITS      = PATTERN_BITS - 3 * WORD_BITS;
    localparam int SPAN_OFFSET   = WIN_BITS + 1 - PATTERN_BITS;
    localparam int COUNT_BITS    = 32;
    localparam int LANE_BITS     = $clog2(WORD_BITS);
    localparam int POS_BITS      = COUNT_BITS + LANE_BITS;
    localparam int OUT_DATA_BITS = ((POS_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PATTERN_LOW   = 3'd0,
        REG_PATTERN_MID   = 3'd1,
        REG_PATTERN_UPPER = 3'd2,
        REG_PATTERN_TOP   = 3'd3,
        REG_END_LIMIT     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                  restart;
        logic [COUNT_BITS-1:0] count;
        logic [SPAN_BITS-1:0]  span_bits;
    } stage_t;

    typedef struct packed {
        logic                hit;
        logic [POS_BITS-1:0] start;
    } search_t;

endpackage

[rtl/bps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_front
// Input register: word window, word count and the registered search stage.
// ----------------------------------------------------------------------------
module bps_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [bps_pkg::WORD_BITS-1:0] in_word,
    input  logic                          in_restart,
    input  logic                          down_ready,
    output logic                          in_ready,
    output logic                          stage_valid,
    output bps_pkg::stage_t               stage
);

    logic [bps_pkg::WIN_BITS-1:0]   window_reg;
    logic [bps_pkg::WIN_BITS-1:0]   window_next;
    logic [bps_pkg::COUNT_BITS-1:0] count_reg;
    logic [bps_pkg::COUNT_BITS-1:0] count_next;
    logic                           valid_reg;
    logic                           valid_next;
    bps_pkg::stage_t                stage_reg;
    bps_pkg::stage_t                stage_next;
    logic                           accept;
    logic [bps_pkg::WIN_BITS-1:0]   cur_window;
    logic [bps_pkg::COUNT_BITS-1:0] cur_count;
    logic [bps_pkg::SPAN_BITS-1:0]  cur_span;

    assign in_ready    = !valid_reg || down_ready;
    assign accept      = in_valid && in_ready;
    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

    always_comb
    begin
        cur_window  = in_restart ? '0 : window_reg;
        cur_count   = in_restart ? '0 : count_reg;
        cur_span    = {in_word, cur_window};
        window_next = window_reg;
        count_next  = count_reg;
        stage_next  = stage_reg;
        valid_next  = valid_reg && !down_ready;
        if (accept)
        begin
            window_next          = cur_span[bps_pkg::SPAN_BITS-1:bps_pkg::WORD_BITS];
            count_next           = cur_count + 1'b1;
            stage_next.restart   = in_restart;
            stage_next.count     = cur_count;
            stage_next.span_bits = cur_span;
            valid_next           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

endmodule

[rtl/bps_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_search
// Parallel alignment compare over one word of end positions; lowest hit wins.
// ----------------------------------------------------------------------------
module bps_search
(
    input  bps_pkg::stage_t                  stage,
    input  logic [bps_pkg::PATTERN_BITS-1:0] pattern,
    input  logic [bps_pkg::POS_BITS-1:0]     end_limit,
    output bps_pkg::search_t                 result
);

    localparam logic [bps_pkg::POS_BITS-1:0] FIRST_LAST =
        bps_pkg::POS_BITS'(bps_pkg::PATTERN_BITS - 1);

    logic [bps_pkg::WORD_BITS-1:0] lane_ok;
    logic [bps_pkg::LANE_BITS-1:0] sel;
    logic [bps_pkg::POS_BITS-1:0]  last_pos [bps_pkg::WORD_BITS];

    always_comb
    begin
        for (int k = 0; k < bps_pkg::WORD_BITS; k++)
        begin
            last_pos[k] = {stage.count, bps_pkg::LANE_BITS'(k)};
            lane_ok[k]  = (last_pos[k] >= FIRST_LAST) && (last_pos[k] <= end_limit) &&
                (stage.span_bits[bps_pkg::SPAN_OFFSET + k +: bps_pkg::PATTERN_BITS]
                 == pattern);
        end
    end

    always_comb
    begin
        sel = '0;
        for (int k = bps_pkg::WORD_BITS - 1; k >= 0; k--)
        begin
            if (lane_ok[k])
            begin
                sel = bps_pkg::LANE_BITS'(k);
            end
        end
        result.hit   = |lane_ok;
        result.start = {stage.count, sel} - FIRST_LAST;
    end

endmodule

[rtl/bps_best.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_best
// Result register: keep the lowest match start since restart and present it.
// ----------------------------------------------------------------------------
module bps_best
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              stage_valid,
    input  logic                              stage_restart,
    input  bps_pkg::search_t                  result,
    input  logic                              out_ready,
    output logic                              load_ready,
    output logic                              out_valid,
    output logic                              out_found,
    output logic [bps_pkg::OUT_DATA_BITS-1:0] out_start
);

    logic                         valid_reg;
    logic                         valid_next;
    logic                         have_reg;
    logic                         have_next;
    logic [bps_pkg::POS_BITS-1:0] best_reg;
    logic [bps_pkg::POS_BITS-1:0] best_next;
    logic                         load;
    logic                         have_cur;
    logic [bps_pkg::POS_BITS-1:0] best_cur;

    assign load_ready = !valid_reg || out_ready;
    assign load       = stage_valid && load_ready;
    assign out_valid  = valid_reg;
    assign out_found  = have_reg;
    assign out_start  = bps_pkg::OUT_DATA_BITS'(best_reg);

    always_comb
    begin
        have_cur   = stage_restart ? 1'b0 : have_reg;
        best_cur   = stage_restart ? '0 : best_reg;
        have_next  = have_reg;
        best_next  = best_reg;
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            valid_next = 1'b1;
            have_next  = have_cur;
            best_next  = best_cur;
            if (result.hit && (!have_cur || (result.start < best_cur)))
            begin
                have_next = 1'b1;
                best_next = result.start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            have_reg  <= 1'b0;
            best_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            have_reg  <= have_next;
            best_reg  <= best_next;
        end
    end

`ifndef ASSERT_OFF
    a_best_never_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !stage_restart && have_reg) |=> (best_reg <= $past(best_reg)))
        else $error("best start rose without restart");

    a_found_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !stage_restart && have_reg) |=> have_reg)
        else $error("match flag dropped without restart");
`endif

endmodule

[rtl/bitstream_pattern_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitstream_pattern_search
// Sync word search: lowest start of a 200-bit pattern in a word stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries 64 stream bits per transfer, bit 0 earliest; s_tuser is
//   the restart flag, which clears the window, position count and match
//   before that word. Each input transfer yields exactly one output
//   transfer: m_tuser is the found flag, m_tdata the lowest matching start
//   (zero until a match is found). The pattern and end limit are written on
//   the cfg channel (always ready) while the block is idle.
//   An input transfer reaches m_tvalid through the input stage register and
//   the result register; throughput is one word per cycle while m_tready is
//   high, set by 64 parallel 200-bit compares between those two registers.
//   Reset clears the window, count, match and registers (end limit to all
//   ones). When m_tready is low the result holds, one more word is taken
//   into the input stage, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module bitstream_pattern_search
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bps_pkg::WORD_BITS-1:0]     s_tdata,   // [63:0] stream_word
    input  logic                              s_tuser,   // [0] restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bps_pkg::OUT_DATA_BITS-1:0] m_tdata,   // [37:0] match_start, zero fill
    output logic                              m_tuser,   // [0] found
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [bps_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    logic [bps_pkg::PATTERN_BITS-1:0] pattern_reg;
    logic [bps_pkg::PATTERN_BITS-1:0] pattern_next;
    logic [bps_pkg::POS_BITS-1:0]     limit_reg;
    logic [bps_pkg::POS_BITS-1:0]     limit_next;
    logic                             stage_valid;
    bps_pkg::stage_t                  stage;
    bps_pkg::search_t                 result;
    logic                             load_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        pattern_next = pattern_reg;
        limit_next   = limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (bps_pkg::cfg_reg_t'(cfg_index))
                bps_pkg::REG_PATTERN_LOW:
                    pattern_next[0 +: bps_pkg::WORD_BITS] = cfg_data;
                bps_pkg::REG_PATTERN_MID:
                    pattern_next[bps_pkg::WORD_BITS +: bps_pkg::WORD_BITS] = cfg_data;
                bps_pkg::REG_PATTERN_UPPER:
                    pattern_next[2 * bps_pkg::WORD_BITS +: bps_pkg::WORD_BITS] = cfg_data;
                bps_pkg::REG_PATTERN_TOP:
                    pattern_next[3 * bps_pkg::WORD_BITS +: bps_pkg::TOP_BITS] =
                        cfg_data[bps_pkg::TOP_BITS-1:0];
                bps_pkg::REG_END_LIMIT:
                    limit_next = cfg_data[bps_pkg::POS_BITS-1:0];
                default:
                begin
                    pattern_next = pattern_reg;
                    limit_next   = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            limit_reg   <= '1;
        end
        else
        begin
            pattern_reg <= pattern_next;
            limit_reg   <= limit_next;
        end
    end

    bps_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_word     (s_tdata),
        .in_restart  (s_tuser),
        .down_ready  (load_ready),
        .in_ready    (s_tready),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    bps_search u_search
    (
        .stage     (stage),
        .pattern   (pattern_reg),
        .end_limit (limit_reg),
        .result    (result)
    );

    bps_best u_best
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage_valid   (stage_valid),
        .stage_restart (stage.restart),
        .result        (result),
        .out_ready     (m_tready),
        .load_ready    (load_ready),
        .out_valid     (m_tvalid),
        .out_found     (m_tuser),
        .out_start     (m_tdata)
    );

`ifndef ASSERT_OFF
    a_start_zero_until_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("match start nonzero without a match");

    a_backpressure_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output free");
`endif

endmodule
